// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that holds in the same cycle as its trigger.
`define CDHP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cdhp: same-cycle check failed");

// Check that holds in the cycle after its trigger.
`define CDHP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cdhp: next-cycle check failed");

`endif

// ===== rtl/cdhp_pkg.sv =====
`default_nettype none

package cdhp_pkg;

	localparam int ROW_W = 12;
	localparam int POS_W = 15;
	localparam logic [12:0] WILD_COL = 13'd256;

	// command codes
	localparam logic [2:0] CMD_EDGE_WR  = 3'd0;
	localparam logic [2:0] CMD_ACT_WR   = 3'd1;
	localparam logic [2:0] CMD_START    = 3'd2;
	localparam logic [2:0] CMD_DATA     = 3'd3;
	localparam logic [2:0] CMD_END      = 3'd4;

	// result status codes
	localparam logic [2:0] STAT_PARSED  = 3'd0;
	localparam logic [2:0] STAT_DONE    = 3'd1;
	localparam logic [2:0] STAT_NUL     = 3'd2;
	localparam logic [2:0] STAT_IGNORED = 3'd3;
	localparam logic [2:0] STAT_ENDED   = 3'd4;

	// action kinds
	localparam logic [7:0] KIND_OPEN  = 8'd1;
	localparam logic [7:0] KIND_CLOSE = 8'd2;

	typedef struct packed {
		logic [2:0]       cmd;
		logic [11:0]      table_index;
		logic [31:0]      table_word;
		logic [7:0]       byte_value;
		logic             skip_nul_enable;
		logic [POS_W-1:0] nul_prefix_start;
	} req_item_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [POS_W-1:0] byte_count;
		logic             capture_valid;
		logic [3:0]       capture_id;
		logic [POS_W-1:0] capture_start;
		logic [POS_W-1:0] capture_length;
		logic [POS_W-1:0] nul_prefix_end;
	} rsp_item_t;

	typedef struct packed {
		logic        en;
		logic [11:0] addr;
		logic [31:0] data;
	} edge_wr_t;

	typedef struct packed {
		logic             en;
		logic [ROW_W-1:0] row;
		logic [ROW_W-1:0] row_mod;
		logic [7:0]       byte_val;
	} edge_rd_t;

	typedef struct packed {
		logic [ROW_W-1:0] next_row;
		logic [ROW_W-1:0] next_mod;
		logic [7:0]       act_id;
	} edge_res_t;

	// Restoring reduction of x by a small constant d; valid while x < 256 * d.
	function automatic logic [11:0] mod_small(input logic [11:0] x, input logic [12:0] d);
		logic [20:0] r;
		logic [20:0] dk;
		r = 21'(x);
		for (int k = 7; k >= 0; k--) begin
			dk = 21'(d) << k;
			if (r >= dk) begin
				r = r - dk;
			end
		end
		return r[11:0];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/cdhp_edge_lookup.sv =====
`default_nettype none

module cdhp_edge_lookup #(
	parameter int EDGE_SLOTS   = 4096,
	parameter int ACTION_SLOTS = 256,
	parameter int ANY_ROW      = 1
) (
	input  wire                 clk,
	input  cdhp_pkg::edge_wr_t  wr,
	input  cdhp_pkg::edge_rd_t  rd,
	output cdhp_pkg::edge_res_t res
);
	import cdhp_pkg::*;

	localparam int EA_W    = $clog2(EDGE_SLOTS);
	localparam int AA_W    = $clog2(ACTION_SLOTS);
	localparam int AID_LO  = 0;
	localparam int NMOD_LO = AA_W;
	localparam int NEXT_LO = AA_W + EA_W;
	localparam int ROW_LO  = NEXT_LO + ROW_W;
	localparam int EW      = ROW_LO + ROW_W;

	localparam logic [12:0]      SLOTS_L = 13'(EDGE_SLOTS);
	localparam logic [ROW_W-1:0] ANY_L   = ROW_W'(ANY_ROW);
	localparam logic [ROW_W-1:0] ANY_MOD = ROW_W'(ANY_ROW % EDGE_SLOTS);

	logic [EW-1:0] mem [EDGE_SLOTS];
	logic [EW-1:0] q0_q;
	logic [EW-1:0] q1_q;
	logic [ROW_W-1:0] row_q;

	logic [11:0]   nmod_w;
	logic [11:0]   aid_w;
	logic [EW-1:0] wr_entry;
	logic [12:0]   sum0;
	logic [12:0]   sum1;
	logic [EA_W-1:0] a0;
	logic [EA_W-1:0] a1;
	logic          hit0;
	logic          hit1;
	logic [EW-1:0] sel;

	// reduce next row and action id once, on the way into the table
	always_comb begin
		nmod_w   = mod_small(wr.data[23:12], SLOTS_L);
		aid_w    = mod_small({4'd0, wr.data[31:24]}, 13'(ACTION_SLOTS));
		wr_entry = {wr.data[11:0], wr.data[23:12], nmod_w[EA_W-1:0], aid_w[AA_W-1:0]};
	end

	// row_mod < EDGE_SLOTS and byte or wildcard <= 256 <= EDGE_SLOTS: one subtract suffices
	always_comb begin
		sum0 = {1'b0, rd.row_mod} + 13'(rd.byte_val);
		sum1 = {1'b0, rd.row_mod} + WILD_COL;
		if (sum0 >= SLOTS_L) begin
			sum0 = sum0 - SLOTS_L;
		end
		if (sum1 >= SLOTS_L) begin
			sum1 = sum1 - SLOTS_L;
		end
		a0 = sum0[EA_W-1:0];
		a1 = sum1[EA_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr[EA_W-1:0]] <= wr_entry;
		end
		if (rd.en) begin
			q0_q  <= mem[a0];
			q1_q  <= mem[a1];
			row_q <= rd.row;
		end
	end

	// byte column first, then wildcard column, else fall to the catch-all row
	always_comb begin
		hit0 = (q0_q[ROW_LO +: ROW_W] == row_q);
		hit1 = (q1_q[ROW_LO +: ROW_W] == row_q);
		sel  = hit0 ? q0_q : q1_q;
		if (hit0 || hit1) begin
			res.next_row = sel[NEXT_LO +: ROW_W];
			res.next_mod = ROW_W'(sel[NMOD_LO +: EA_W]);
			res.act_id   = 8'(sel[AID_LO +: AA_W]);
		end else begin
			res.next_row = ANY_L;
			res.next_mod = ANY_MOD;
			res.act_id   = 8'd0;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/compressed_dfa_header_parser.sv =====
`default_nettype none
// Row-displacement compressed DFA header parser. Request transactions load
// edge and action tables, start a message, feed data bytes and end the
// message; each data byte and each end transaction returns one response
// transaction (status, done count, closed capture range, NUL prefix end).
// A parsed data byte reads the dual-port edge memory (byte column and
// wildcard column at once), then the action memory; a byte whose first
// lookup lands on the catch-all row makes another edge memory read for
// the catch-all lookup in between. Table writes, start, end, ignored bytes
// and skipped NUL bytes need no table walk. The next parsed byte issues its
// edge read in the same cycle the previous byte's action resolves. After
// reset a clearing pass over the EDGE_SLOTS edge addresses zeroes the edge
// and action memories; no request transaction is accepted during it, while
// configuration writes are taken at any time. Capture ranges read a small
// capture-start memory; its entries carry valid bits cleared on start.
// Responses sit in an output register behind a finish stage, so requests
// keep flowing while a response waits on rsp_stall until that stage fills.

module compressed_dfa_header_parser #(
	parameter int EDGE_SLOTS   = 4096,
	parameter int ACTION_SLOTS = 256,
	parameter int MATCH_SLOTS  = 16,
	parameter int MSG_BYTES    = 16384,
	parameter int ANY_ROW      = 1
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  req_valid,
	output logic                 req_stall,
	input  cdhp_pkg::req_item_t  req,
	output logic                 rsp_valid,
	input  wire                  rsp_stall,
	output cdhp_pkg::rsp_item_t  rsp,
	input  wire                  cfg_valid,
	output logic                 cfg_ready,
	input  wire [11:0]           cfg_data
);
	import cdhp_pkg::*;

	`include "assert_macros.svh"

	localparam int EA_W = $clog2(EDGE_SLOTS);
	localparam int AA_W = $clog2(ACTION_SLOTS);
	localparam int MW   = (MATCH_SLOTS > 1) ? $clog2(MATCH_SLOTS) : 1;
	localparam int AW   = 9 + MW;

	localparam logic [ROW_W-1:0] ANY_ROW_L = ROW_W'(ANY_ROW);
	localparam logic [ROW_W-1:0] ANY_MOD   = ROW_W'(ANY_ROW % EDGE_SLOTS);
	localparam logic [POS_W-1:0] MSG_LIM   = POS_W'(MSG_BYTES);
	localparam logic [12:0]      EDGE_LIM  = 13'(EDGE_SLOTS);
	localparam logic [12:0]      ACT_LIM   = 13'(ACTION_SLOTS);
	localparam logic [EA_W-1:0]  CLR_LAST  = EA_W'(EDGE_SLOTS - 1);

	// sequencer states
	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_RUN   = 3'd1;
	localparam logic [2:0] ST_EDGE1 = 3'd2;
	localparam logic [2:0] ST_EDGE2 = 3'd3;
	localparam logic [2:0] ST_ACT   = 3'd4;

	logic [2:0]       st_q;
	logic [EA_W-1:0]  clr_q;

	// request holding register
	logic             in_v_q;
	req_item_t        in_q;

	// walk state
	logic [ROW_W-1:0] init_row_q;
	logic [ROW_W-1:0] init_mod_q;
	logic [ROW_W-1:0] cur_row_q;
	logic [ROW_W-1:0] row_mod_q;
	logic [POS_W-1:0] pos_q;
	logic             done_q;
	logic             nul_on_q;
	logic [POS_W-1:0] nul_next_q;
	logic [7:0]       byte_q;

	// action memory: kind, done flag, reduced match id
	logic [AW-1:0]    act_mem [ACTION_SLOTS];
	logic [AW-1:0]    act_rd_q;

	// capture start memory with per-entry valid bits
	logic [POS_W-1:0] cap_mem [MATCH_SLOTS];
	logic [MATCH_SLOTS-1:0] cap_vld_q;
	logic [POS_W-1:0] cap_rd_q;
	logic             cap_rdv_q;

	// finish stage and output register
	logic             fin_v_s1;
	rsp_item_t        fin_s1;
	logic             fin_cap_s1;
	logic [MW-1:0]    fin_mid_s1;
	logic [POS_W-1:0] fin_pos_s1;
	logic             out_v_q;
	rsp_item_t        rsp_q;

	edge_wr_t         ewr;
	edge_rd_t         erd;
	edge_res_t        res;

	logic             out_free;
	logic             fin_mv;
	logic             fin_free;
	logic [7:0]       a_kind;
	logic             a_done;
	logic [MW-1:0]    a_mid;
	logic             act_emit;
	logic [POS_W-1:0] pos_inc;
	logic [POS_W-1:0] pos_eff;
	logic             done_eff;
	logic             is_edge_wr;
	logic             is_act_wr;
	logic             is_start;
	logic             is_data;
	logic             is_end;
	logic             byte_ignore;
	logic             byte_skip;
	logic             byte_parse;
	logic             need_fin;
	logic             take;
	logic             accept;
	logic             reissue;
	logic             act_rd_en;
	logic             act_wr_en;
	logic [AA_W-1:0]  act_wr_addr;
	logic [AW-1:0]    act_wr_data;
	logic [11:0]      mid_red;
	logic             cap_wr_en;
	logic             cap_rd_en;
	logic             fin_load;
	rsp_item_t        fin_next;
	logic             fin_cap_next;
	logic [11:0]      init_mod_w;
	rsp_item_t        out_next;
	logic [POS_W-1:0] cap_st;

	cdhp_edge_lookup #(
		.EDGE_SLOTS   (EDGE_SLOTS),
		.ACTION_SLOTS (ACTION_SLOTS),
		.ANY_ROW      (ANY_ROW)
	) u_lookup (
		.clk (clk),
		.wr  (ewr),
		.rd  (erd),
		.res (res)
	);

	assign cfg_ready = 1'b1;
	assign init_mod_w = mod_small(cfg_data, EDGE_LIM);

	// output handshake and finish stage flow
	assign out_free = !out_v_q || !rsp_stall;
	assign fin_mv   = fin_v_s1 && out_free;
	assign fin_free = !fin_v_s1 || out_free;

	assign a_kind = act_rd_q[AW-1 -: 8];
	assign a_done = act_rd_q[MW];
	assign a_mid  = act_rd_q[MW-1:0];

	// resolve the action of the byte in flight once the finish stage can take it
	assign act_emit = (st_q == ST_ACT) && fin_free;
	assign pos_inc  = pos_q + 15'd1;
	assign pos_eff  = act_emit ? pos_inc : pos_q;
	assign done_eff = done_q || (act_emit && a_done);

	assign is_edge_wr = (in_q.cmd == CMD_EDGE_WR);
	assign is_act_wr  = (in_q.cmd == CMD_ACT_WR);
	assign is_start   = (in_q.cmd == CMD_START);
	assign is_data    = (in_q.cmd == CMD_DATA);
	assign is_end     = (in_q.cmd == CMD_END);

	assign byte_ignore = done_eff || (pos_eff >= MSG_LIM);
	assign byte_skip   = !byte_ignore && nul_on_q && (in_q.byte_value == 8'd0)
		&& (pos_eff == nul_next_q);
	assign byte_parse  = is_data && !byte_ignore && !byte_skip;
	assign need_fin    = is_end || (is_data && !byte_parse);

	// while an action resolves, take only transactions that leave the finish stage alone
	assign take = in_v_q && (((st_q == ST_RUN) && (!need_fin || fin_free))
		|| (act_emit && !need_fin));
	assign req_stall = (st_q == ST_CLEAR) || (in_v_q && !take);
	assign accept    = req_valid && !req_stall;

	// edge memory ports
	assign reissue = (st_q == ST_EDGE1) && (res.next_row == ANY_ROW_L);

	always_comb begin
		erd.en       = (take && byte_parse) || reissue;
		erd.row      = (st_q == ST_EDGE1) ? ANY_ROW_L : cur_row_q;
		erd.row_mod  = (st_q == ST_EDGE1) ? ANY_MOD : row_mod_q;
		erd.byte_val = (st_q == ST_EDGE1) ? byte_q : in_q.byte_value;
	end

	always_comb begin
		if (st_q == ST_CLEAR) begin
			ewr.en   = 1'b1;
			ewr.addr = 12'(clr_q);
			ewr.data = 32'd0;
		end else begin
			ewr.en   = take && is_edge_wr && ({1'b0, in_q.table_index} < EDGE_LIM);
			ewr.addr = in_q.table_index;
			ewr.data = in_q.table_word;
		end
	end

	// action memory ports
	assign act_rd_en = ((st_q == ST_EDGE1) && !reissue) || (st_q == ST_EDGE2);
	assign mid_red   = mod_small({4'd0, in_q.table_word[23:16]}, 13'(MATCH_SLOTS));

	always_comb begin
		if (st_q == ST_CLEAR) begin
			act_wr_en   = (13'(clr_q) < ACT_LIM);
			act_wr_addr = clr_q[AA_W-1:0];
			act_wr_data = '0;
		end else begin
			act_wr_en   = take && is_act_wr && ({1'b0, in_q.table_index} < ACT_LIM);
			act_wr_addr = in_q.table_index[AA_W-1:0];
			act_wr_data = {in_q.table_word[7:0], in_q.table_word[8], mid_red[MW-1:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (act_wr_en) begin
			act_mem[act_wr_addr] <= act_wr_data;
		end
		if (act_rd_en) begin
			act_rd_q <= act_mem[res.act_id[AA_W-1:0]];
		end
	end

	// capture memory: open writes position + 1, close reads the start back
	assign cap_wr_en = act_emit && (a_kind == KIND_OPEN);
	assign cap_rd_en = act_emit && (a_kind == KIND_CLOSE);

	always_ff @(posedge clk) begin
		if (cap_wr_en) begin
			cap_mem[a_mid] <= pos_inc;
		end
		if (cap_rd_en) begin
			cap_rd_q  <= cap_mem[a_mid];
			cap_rdv_q <= cap_vld_q[a_mid];
		end
	end

	// build the finish stage entry
	assign fin_load = act_emit || (take && need_fin);

	always_comb begin
		fin_next                = '0;
		fin_next.nul_prefix_end = nul_next_q;
		fin_cap_next            = 1'b0;
		if (act_emit) begin
			fin_next.status     = a_done ? STAT_DONE : STAT_PARSED;
			fin_next.byte_count = a_done ? pos_inc : '0;
			fin_cap_next        = (a_kind == KIND_CLOSE);
		end else if (is_end) begin
			fin_next.status     = done_q ? STAT_IGNORED : STAT_ENDED;
			fin_next.byte_count = done_q ? '0 : pos_q;
		end else if (byte_skip) begin
			fin_next.status         = STAT_NUL;
			fin_next.nul_prefix_end = pos_inc;
		end else begin
			fin_next.status = STAT_IGNORED;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			fin_s1     <= fin_next;
			fin_cap_s1 <= fin_cap_next;
			fin_mid_s1 <= a_mid;
			fin_pos_s1 <= pos_q;
		end
	end

	// merge the capture range on the way to the output register
	always_comb begin
		cap_st   = cap_rdv_q ? cap_rd_q : '0;
		out_next = fin_s1;
		if (fin_cap_s1) begin
			out_next.capture_valid  = 1'b1;
			out_next.capture_id     = 4'(fin_mid_s1);
			out_next.capture_start  = cap_st;
			out_next.capture_length = fin_pos_s1 - cap_st + 15'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_mv) begin
			rsp_q <= out_next;
		end
		if (accept) begin
			in_q <= req;
		end
		if (take && byte_parse) begin
			byte_q <= in_q.byte_value;
		end
	end

	assign rsp_valid = out_v_q;
	assign rsp       = rsp_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_CLEAR;
			clr_q      <= '0;
			in_v_q     <= 1'b0;
			fin_v_s1   <= 1'b0;
			out_v_q    <= 1'b0;
			init_row_q <= '0;
			init_mod_q <= '0;
			cur_row_q  <= '0;
			row_mod_q  <= '0;
			pos_q      <= '0;
			done_q     <= 1'b0;
			nul_on_q   <= 1'b0;
			nul_next_q <= '0;
			cap_vld_q  <= '0;
		end else begin
			in_v_q   <= accept || (in_v_q && !take);
			fin_v_s1 <= fin_load || (fin_v_s1 && !fin_mv);
			out_v_q  <= fin_mv || (out_v_q && rsp_stall);

			if (cfg_valid && cfg_ready) begin
				init_row_q <= cfg_data;
				init_mod_q <= init_mod_w;
			end

			unique case (st_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_LAST) begin
						st_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (take && byte_parse) begin
						st_q <= ST_EDGE1;
					end
				end
				ST_EDGE1: begin
					st_q <= reissue ? ST_EDGE2 : ST_ACT;
				end
				ST_EDGE2: begin
					st_q <= ST_ACT;
				end
				ST_ACT: begin
					if (act_emit) begin
						st_q <= (take && byte_parse) ? ST_EDGE1 : ST_RUN;
					end
				end
				default: begin
					st_q <= ST_RUN;
				end
			endcase

			// advance the row once its lookup settles
			if (act_rd_en) begin
				cur_row_q <= res.next_row;
				row_mod_q <= res.next_mod;
			end

			if (act_emit) begin
				pos_q  <= pos_inc;
				done_q <= done_q || a_done;
			end
			if (cap_wr_en) begin
				cap_vld_q[a_mid] <= 1'b1;
			end
			if (take && is_data && byte_skip) begin
				pos_q      <= pos_inc;
				nul_next_q <= pos_inc;
			end
			// start wins over anything resolving in the same cycle
			if (take && is_start) begin
				cur_row_q  <= init_row_q;
				row_mod_q  <= init_mod_q;
				pos_q      <= '0;
				done_q     <= 1'b0;
				nul_on_q   <= in_q.skip_nul_enable;
				nul_next_q <= in_q.nul_prefix_start;
				cap_vld_q  <= '0;
			end
		end
	end

	`CDHP_ASSERT_NOW(a_no_take_in_clear, st_q == ST_CLEAR, !take && req_stall)
	`CDHP_ASSERT_NEXT(a_act_holds, st_q == ST_ACT && !fin_free, st_q == ST_ACT)
	`CDHP_ASSERT_NOW(a_cap_read_feeds_fin, cap_rd_en, fin_load && fin_cap_next)
	`CDHP_ASSERT_NEXT(a_edge_reissue, reissue, st_q == ST_EDGE2)

endmodule

`default_nettype wire
